### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the ordered list RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is ignored while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is checked during reset as well.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/oaid_pkg.sv
// ----------------------------------------------------------------------------
// oaid_pkg
// Types and constants for the ordered list with insert and delete.
// ----------------------------------------------------------------------------
package oaid_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 5;
    localparam int FILL_W   = 5;
    localparam int WORD_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    // Request codes.
    localparam logic [1:0] REQ_APPEND = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_DELETE = 2'd2;
    localparam logic [1:0] REQ_LIST   = 2'd3;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [POS_W-1:0]          position;
        logic signed [WORD_W-1:0]  value;
    } in_item_t;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [WORD_W-1:0]  data_word;
        logic [FILL_W-1:0]         fill_count;
        logic                      last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_INSERT,
        OP_DELETE,
        OP_ROTATE
    } cell_op_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        cell_op_t          op;
        logic [IDX_W-1:0]  pos;
        logic [IDX_W-1:0]  last_idx;
    } cell_ctl_t;

endpackage

### rtl/oaid_cell.sv
// ----------------------------------------------------------------------------
// oaid_cell
// One storage cell of the list chain: holds a word, or takes the new word,
// its left neighbor, its right neighbor or the head word, by its own index.
// ----------------------------------------------------------------------------
module oaid_cell (
    input  logic                              clk,
    input  logic [oaid_pkg::IDX_W-1:0]        idx,
    input  oaid_pkg::cell_ctl_t               ctl,
    input  logic signed [oaid_pkg::WORD_W-1:0] new_word,
    input  logic signed [oaid_pkg::WORD_W-1:0] left_word,
    input  logic signed [oaid_pkg::WORD_W-1:0] right_word,
    input  logic signed [oaid_pkg::WORD_W-1:0] head_word,
    output logic signed [oaid_pkg::WORD_W-1:0] word
);
    import oaid_pkg::*;

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (ctl.op)
            OP_INSERT:
            begin
                if (idx == ctl.pos)
                    word_next = new_word;
                else if (idx > ctl.pos)
                    word_next = left_word;
            end
            OP_DELETE:
            begin
                if (idx >= ctl.pos)
                    word_next = right_word;
            end
            OP_ROTATE:
            begin
                // The stored part of the chain turns by one place, so the
                // head word wraps around to the last stored place.
                if (idx < ctl.last_idx)
                    word_next = right_word;
                else if (idx == ctl.last_idx)
                    word_next = head_word;
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

### rtl/ordered_array_insert_delete.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_delete
// Fixed-capacity ordered list of signed words with append, insert at a
// position, delete at a position and a listing of all entries.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  in      | in_valid / in_ready  | in_item  (req_type, position, value)
//  out     | out_valid / out_ready| out_item (status, data_word, fill_count,
//          |                      |           last)
//
//  Append, insert and delete are done with all cells shifting together, and
//  one such transaction is taken per cycle while the output is drained.
//  A list request holds off the input until every entry is sent: after the
//  request, one entry goes out per cycle while the output is drained, as
//  the stored part of the cell chain rotates once.
//  Reset empties the list at once; the stored words themselves are not reset.
//  A stalled output holds its result and blocks new transactions only when
//  the single output register is still full.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  oaid_pkg::in_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output oaid_pkg::out_item_t  out_item
);
    import oaid_pkg::*;

    `include "assert_macros.svh"

    typedef enum logic {
        S_IDLE,
        S_LIST
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [CNT_W-1:0]    list_left_reg, list_left_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_reg, out_next;

    cell_ctl_t                ctl;
    logic signed [WORD_W-1:0] cell_word [CAPACITY];

    logic              slot_free;
    logic              accept;
    logic              full;
    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic [IDX_W-1:0]  pos_idx;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [WORD_W-1:0] left_w;
        logic signed [WORD_W-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = cell_word[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = cell_word[i+1];
        end

        oaid_cell u_cell (
            .clk        (clk),
            .idx        (IDX_W'(i)),
            .ctl        (ctl),
            .new_word   (in_item.value),
            .left_word  (left_w),
            .right_word (right_w),
            .head_word  (cell_word[0]),
            .word       (cell_word[i])
        );
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign pos_ext   = CMP_W'(in_item.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_idx   = in_item.position[IDX_W-1:0];

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        list_left_next = list_left_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_next       = out_reg;

        ctl.op       = OP_HOLD;
        ctl.pos      = pos_idx;
        ctl.last_idx = IDX_W'(count_reg - CNT_W'(1));

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    out_valid_next      = 1'b1;
                    out_next.status     = ST_OK;
                    out_next.data_word  = '0;
                    out_next.last       = 1'b1;
                    unique case (in_item.req_type)
                        REQ_APPEND:
                        begin
                            if (full)
                                out_next.status = ST_FULL;
                            else
                            begin
                                ctl.op     = OP_INSERT;
                                ctl.pos    = IDX_W'(count_reg);
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_INSERT:
                        begin
                            if (pos_ext > cnt_ext)
                                out_next.status = ST_RANGE;
                            else if (full)
                                out_next.status = ST_FULL;
                            else
                            begin
                                ctl.op     = OP_INSERT;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        REQ_DELETE:
                        begin
                            if (count_reg == '0)
                                out_next.status = ST_EMPTY;
                            else if (pos_ext >= cnt_ext)
                                out_next.status = ST_RANGE;
                            else
                            begin
                                ctl.op             = OP_DELETE;
                                out_next.data_word = cell_word[pos_idx];
                                count_next         = count_reg - CNT_W'(1);
                            end
                        end
                        REQ_LIST:
                        begin
                            if (count_reg == '0)
                                out_next.status = ST_EMPTY;
                            else
                            begin
                                // The entries follow from the list state.
                                out_valid_next = out_valid_reg && !out_ready;
                                out_next       = out_reg;
                                state_next     = S_LIST;
                                list_left_next = count_reg;
                            end
                        end
                        default:
                        begin
                            out_next.status = ST_OK;
                        end
                    endcase
                    out_next.fill_count = FILL_W'(count_next);
                end
            end
            S_LIST:
            begin
                if (slot_free)
                begin
                    ctl.op              = OP_ROTATE;
                    out_valid_next      = 1'b1;
                    out_next.status     = ST_OK;
                    out_next.data_word  = cell_word[0];
                    out_next.fill_count = FILL_W'(count_reg);
                    out_next.last       = (list_left_reg == CNT_W'(1));
                    list_left_next      = list_left_reg - CNT_W'(1);
                    if (list_left_reg == CNT_W'(1))
                        state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            list_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            list_left_reg <= list_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_CLK(a_count_bound, count_reg <= CNT_W'(CAPACITY), "fill count above capacity")
    `ASSERT_CLK(a_list_blocks, (state_reg == S_LIST) |-> !in_ready, "input taken while listing")
    `ASSERT_CLK(a_append_grows, (accept && in_item.req_type == REQ_APPEND && !full) |=> (count_reg == $past(count_reg) + CNT_W'(1)), "append did not grow the list")
    `ASSERT_CLK(a_list_last, (state_reg == S_LIST && slot_free && list_left_reg == CNT_W'(1)) |=> (out_valid && out_item.last && state_reg == S_IDLE), "list end not marked")

endmodule

### tb/sv/ordered_array_insert_delete_test.sv
// ----------------------------------------------------------------------------
// ordered_array_insert_delete_test
// Self-checking bench for the ordered list. A queue of requests feeds a
// bursty driver, a shadow copy of the list predicts every result at the
// moment a request is taken, and a monitor compares each returned
// transaction field by field while the output side stalls in its own pattern.
// ----------------------------------------------------------------------------
module ordered_array_insert_delete_test;
    timeunit 1ns;
    timeprecision 1ps;

    import oaid_pkg::*;

    typedef struct {
        bit       pause;
        in_item_t req;
    } stim_t;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_ready;
    in_item_t  in_item = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    out_item_t out_item;

    // Shadow of the list contents, updated on every accepted request.
    logic signed [WORD_W-1:0] list_words [CAPACITY];
    int                       list_len = 0;

    stim_t     pending_requests [$];
    out_item_t awaited_results [$];
    int        fault_count = 0;
    int        plan_len = 0;
    int        gap_left = 0;
    int        burst_left = 1;
    int        ready_mode = 0;
    int        mode_left = 0;

    ordered_array_insert_delete uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Works out the results of one request and applies it to the shadow list.
    function automatic void apply_request(in_item_t req);
        out_item_t r;
        int        i;
        r = '0;
        r.last = 1'b1;
        case (req.req_type)
            REQ_APPEND:
            begin
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = req.value;
                    list_len++;
                    r.status = ST_OK;
                end
            end
            REQ_INSERT:
            begin
                if (int'(req.position) > list_len)
                    r.status = ST_RANGE;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = list_len; i > int'(req.position); i--)
                        list_words[i] = list_words[i-1];
                    list_words[req.position] = req.value;
                    list_len++;
                    r.status = ST_OK;
                end
            end
            REQ_DELETE:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
                else if (int'(req.position) >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    r.data_word = list_words[req.position];
                    for (i = int'(req.position); i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    r.status = ST_OK;
                end
            end
            default:
            begin
                if (list_len == 0)
                    r.status = ST_EMPTY;
            end
        endcase
        r.fill_count = FILL_W'(list_len);
        if (req.req_type == REQ_LIST && list_len > 0)
        begin
            for (i = 0; i < list_len; i++)
            begin
                r.status    = ST_OK;
                r.data_word = list_words[i];
                r.last      = (i + 1 == list_len);
                awaited_results.push_back(r);
            end
        end
        else
            awaited_results.push_back(r);
    endfunction

    // Queues a request and tracks the fill level it will leave behind, so the
    // random part can aim positions at the live part of the list.
    function automatic void push_request(logic [1:0] kind, int pos, logic [WORD_W-1:0] word);
        stim_t s;
        s.pause            = 1'b0;
        s.req.req_type     = kind;
        s.req.position     = POS_W'(pos);
        s.req.value        = word;
        pending_requests.push_back(s);
        case (kind)
            REQ_APPEND: if (plan_len < CAPACITY) plan_len++;
            REQ_INSERT: if (pos <= plan_len && plan_len < CAPACITY) plan_len++;
            REQ_DELETE: if (plan_len > 0 && pos < plan_len) plan_len--;
            default: ;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 15))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Driver: sends in bursts, holds the payload until it is taken.
    always @(posedge clk or negedge rst_n)
    begin : driver
        logic  send;
        stim_t head;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_item    <= '0;
            gap_left   = 0;
            burst_left = 1;
        end
        else
        begin
            send = 1'b0;
            if (in_valid && in_ready)
                apply_request(in_item);
            if (in_valid && !in_ready)
                send = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else if (pending_requests.size() > 0)
            begin
                if (pending_requests[0].pause)
                begin
                    if (awaited_results.size() == 0)
                        head = pending_requests.pop_front();
                end
                else
                begin
                    head = pending_requests.pop_front();
                    in_item <= head.req;
                    send = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
            in_valid <= send;
        end
    end

    // Output side: long stretches of full rate, random stalls or heavy stalls.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            ready_mode = 0;
            mode_left  = 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 200);
            end
            else
                mode_left--;
            case (ready_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                default: out_ready <= ($urandom_range(0, 4) == 0);
            endcase
        end
    end

    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("unexpected result transaction: status %0d data_word %0d",
                       out_item.status, out_item.data_word);
                fault_count++;
            end
            else
            begin
                want = awaited_results.pop_front();
                if (out_item.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, out_item.status);
                    fault_count++;
                end
                if (out_item.data_word !== want.data_word)
                begin
                    $error("data_word: expected %0d, got %0d",
                           want.data_word, out_item.data_word);
                    fault_count++;
                end
                if (out_item.fill_count !== want.fill_count)
                begin
                    $error("fill_count: expected %0d, got %0d",
                           want.fill_count, out_item.fill_count);
                    fault_count++;
                end
                if (out_item.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_item.last);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin : stimulus
        stim_t      hold_point;
        logic [1:0] edit_kinds [3];
        logic [1:0] kind;
        bit         filling;
        int         n;
        int         pos;
        int         pick;

        edit_kinds = '{REQ_APPEND, REQ_INSERT, REQ_DELETE};
        hold_point.pause = 1'b1;
        hold_point.req   = '0;

        // Empty list corner cases, then a small list with range errors.
        push_request(REQ_LIST,   0,  rand_word());
        push_request(REQ_DELETE, 0,  rand_word());
        push_request(REQ_INSERT, 1,  32'h1234_5678);
        push_request(REQ_INSERT, 0,  32'h7FFF_FFFF);
        push_request(REQ_APPEND, 31, 32'h8000_0000);
        push_request(REQ_INSERT, 2,  32'hFFFF_FFFF);
        push_request(REQ_INSERT, 4,  32'h0000_0001);
        push_request(REQ_INSERT, 31, 32'h0000_0002);
        push_request(REQ_DELETE, 3,  rand_word());
        push_request(REQ_DELETE, 31, rand_word());
        push_request(REQ_LIST,   31, rand_word());
        push_request(REQ_DELETE, 1,  rand_word());
        push_request(REQ_DELETE, 0,  rand_word());
        // Fill to capacity and hit every full case.
        for (n = 0; n < CAPACITY - 1; n++)
            push_request(REQ_APPEND, 0, (n % 2 == 0) ? 32'h5555_5555 : 32'hAAAA_AAAA);
        push_request(REQ_APPEND, 0,  rand_word());
        push_request(REQ_INSERT, 5,  rand_word());
        push_request(REQ_INSERT, 16, rand_word());
        push_request(REQ_INSERT, 17, rand_word());
        push_request(REQ_LIST,   0,  rand_word());
        push_request(REQ_DELETE, 16, rand_word());
        push_request(REQ_DELETE, 15, rand_word());
        push_request(REQ_DELETE, 0,  rand_word());
        pending_requests.push_back(hold_point);

        // Random part: fill and drain phases with mostly in-range positions.
        filling = 1'b0;
        for (n = 0; n < 460; n++)
        begin
            if (plan_len == CAPACITY)
                filling = 1'b0;
            else if (plan_len == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 39) == 0)
                filling = !filling;
            pick = $urandom_range(0, 99);
            if (pick < 8)
                kind = REQ_LIST;
            else if (pick < 50)
                kind = filling ? REQ_INSERT : REQ_DELETE;
            else if (pick < 80)
                kind = filling ? REQ_APPEND : REQ_DELETE;
            else
                kind = edit_kinds[$urandom_range(0, 2)];
            if ($urandom_range(0, 9) < 8)
            begin
                if (kind == REQ_INSERT)
                    pos = $urandom_range(0, plan_len);
                else
                    pos = (plan_len > 0) ? $urandom_range(0, plan_len - 1) : 0;
            end
            else
                pos = $urandom_range(0, 31);
            push_request(kind, pos, rand_word());
            if (n % 150 == 149)
                pending_requests.push_back(hold_point);
        end

        repeat (3) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        while (pending_requests.size() > 0 || in_valid || awaited_results.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/oaid_pkg.sv
rtl/oaid_cell.sv
rtl/ordered_array_insert_delete.sv
tb/sv/ordered_array_insert_delete_test.sv
